/* hw/rtl/sacp_pkg.sv */
// ---------------------------------------------------------------------------
// sacp_pkg
// Shared types and constants of the set-associative cache controller.
// ---------------------------------------------------------------------------
`default_nettype none

package sacp_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned BLKNUM_W = 27;
  localparam int unsigned PFCNT_W = 3;

  localparam logic CMD_READ = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] addr;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic        buffer_hit;
    logic        miss_counted;
    logic        fetch_needed;
    logic        writeback;
    logic [31:0] writeback_addr;
    logic [2:0]  prefetch_count;
    logic [26:0] prefetch_first_block;
  } rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/set_assoc_cache_with_stream_prefetch_core.sv */
// ---------------------------------------------------------------------------
// set_assoc_cache_with_stream_prefetch_core
// Write-back cache tag controller with LRU stream-buffer prefetching.
// ---------------------------------------------------------------------------
// channel  dir  tdata fields (low bit up)                    tuser
// s_axis   in   addr[31:0]                                   cmd
// m_axis   out  hit, buffer_hit, miss_counted, fetch_needed, -
//               writeback, writeback_addr, prefetch_count,
//               prefetch_first_block
// cfg      in   prefetch_enable                              -
// An access goes from the input transfer into the request queue; the set
// row is read at the edge that takes it out of the queue, and the row
// update and result register follow in the execute state once the output
// register is free; no new request is taken until then. rst is synchronous;
// per-set valid bits stand in for clearing the line memory. Output stalls
// hold the back end; the queue keeps taking requests until full.
`default_nettype none

module set_assoc_cache_with_stream_prefetch_core
  import sacp_pkg::*;
#(
  parameter int unsigned SETS = 64,
  parameter int unsigned WAYS = 4,
  parameter int unsigned BLOCK_BYTES = 32,
  parameter int unsigned NUM_STREAMS = 4,
  parameter int unsigned STREAM_DEPTH = 4
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire         cfg_wdata,       // prefetch_enable
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire [31:0]  s_axis_tdata,    // addr[31:0]
  input  wire         s_axis_tuser,    // cmd
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [71:0] m_axis_tdata     // hit, bhit, miss, fetch, wb, wb_addr[36:5],
                                       // pf_count[39:37], pf_first[66:40]
);

  logic pf_en;
  logic q_valid, q_ready;
  req_t in_req, q_req;
  rsp_t rsp;

  assign in_req.cmd = s_axis_tuser;
  assign in_req.addr = s_axis_tdata;

  always_ff @(posedge clk) begin
    if (rst) pf_en <= 1'b0;
    else if (cfg_we) pf_en <= cfg_wdata;
  end

  sacp_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req(in_req),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
  );

  sacp_back #(
    .SETS(SETS), .WAYS(WAYS), .BLOCK_BYTES(BLOCK_BYTES),
    .NUM_STREAMS(NUM_STREAMS), .STREAM_DEPTH(STREAM_DEPTH)
  ) u_back (
    .clk(clk), .rst(rst), .pf_en(pf_en),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_rsp(rsp)
  );

  assign m_axis_tdata = {5'd0, rsp.prefetch_first_block, rsp.prefetch_count,
                         rsp.writeback_addr, rsp.writeback, rsp.fetch_needed,
                         rsp.miss_counted, rsp.buffer_hit, rsp.hit};

endmodule

`default_nettype wire

/* hw/rtl/sacp_front.sv */
// ---------------------------------------------------------------------------
// sacp_front
// Input stage and two-entry request queue toward the lookup engine.
// ---------------------------------------------------------------------------
`default_nettype none

module sacp_front
  import sacp_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire req_t  in_req,
  output logic       q_valid,
  input  wire        q_ready,
  output req_t       q_req
);

  req_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready = (count != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (count != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_req = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_req;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sacp_back.sv */
// ---------------------------------------------------------------------------
// sacp_back
// Tag lookup, LRU update, replacement and stream-buffer prefetch engine.
// ---------------------------------------------------------------------------
`default_nettype none

module sacp_back
  import sacp_pkg::*;
#(
  parameter int unsigned SETS = 64,
  parameter int unsigned WAYS = 4,
  parameter int unsigned BLOCK_BYTES = 32,
  parameter int unsigned NUM_STREAMS = 4,
  parameter int unsigned STREAM_DEPTH = 4
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        pf_en,
  input  wire        q_valid,
  output logic       q_ready,
  input  wire req_t  q_req,
  output logic       out_valid,
  input  wire        out_ready,
  output rsp_t       out_rsp
);

  localparam int unsigned OB = $clog2(BLOCK_BYTES);
  localparam int unsigned IB = (SETS > 1) ? $clog2(SETS) : 0;
  localparam int unsigned SW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned NW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int unsigned TW = ADDR_W - OB - IB;
  localparam int unsigned BW = ADDR_W - OB;
  localparam logic [WW-1:0] WAY_LAST = WW'(WAYS - 1);
  localparam logic [NW-1:0] STR_LAST = NW'(NUM_STREAMS - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  // line state memory: one row per set
  logic [WAYS-1:0]        vld_mem  [SETS];
  logic [WAYS-1:0]        drt_mem  [SETS];
  logic [WAYS*TW-1:0]     tag_mem  [SETS];
  logic [WAYS*WW-1:0]     rnk_mem  [SETS];
  logic [SETS-1:0]        row_init;

  logic [WAYS-1:0]        r_vld, r_drt;
  logic [WAYS*TW-1:0]     r_tag;
  logic [WAYS*WW-1:0]     r_rnk;
  logic                   r_init;

  logic [BW-1:0]          sblk [NUM_STREAMS][STREAM_DEPTH];
  logic [NW-1:0]          srank [NUM_STREAMS];
  logic [NUM_STREAMS-1:0] svalid;

  logic                   state;
  req_t                   cur;
  logic                   out_full;

  logic [BW-1:0] blk;
  logic [SW-1:0] set_q, set_in;
  logic [TW-1:0] tag;

  assign blk = cur.addr[ADDR_W-1:OB];
  assign tag = cur.addr[ADDR_W-1:OB+IB];
  assign set_q = (SETS > 1) ? SW'(cur.addr[OB +: SW]) : '0;
  assign set_in = (SETS > 1) ? SW'(q_req.addr[OB +: SW]) : '0;

  assign q_ready = (state == ST_IDLE);
  assign out_valid = out_full;

  // execute-stage combinational logic
  logic [WAYS-1:0]     e_vld, e_drt;
  logic [WAYS*WW-1:0]  e_rnk, n_rnk;
  logic [WAYS*TW-1:0]  n_tag;
  logic                hit;
  logic [WW-1:0]       hway, vict, tway;
  logic [WW-1:0]       trank;
  logic                bfound;
  logic [NW-1:0]       bsel, asel, tstr;
  logic [NW-1:0]       brank;
  logic [PFCNT_W-1:0]  bpos;
  logic                bm;
  logic                do_alloc;
  logic [NW-1:0]       srank_next [NUM_STREAMS];
  logic                stouch;
  logic [NW-1:0]       strank;
  rsp_t                rsp;
  logic [BW-1:0]       fblk;

  always_comb begin
    e_vld = r_init ? r_vld : '0;
    e_drt = r_init ? r_drt : '0;
    for (int i = 0; i < WAYS; i++) begin
      e_rnk[i*WW +: WW] = r_init ? r_rnk[i*WW +: WW] : WW'(i);
    end
    hit = 1'b0;
    hway = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (e_vld[i] && r_tag[i*TW +: TW] == tag) begin
        hit = 1'b1;
        hway = WW'(i);
      end
    end
    vict = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (e_rnk[i*WW +: WW] == WAY_LAST) vict = WW'(i);
    end
    tway = hit ? hway : vict;
    trank = e_rnk[tway*WW +: WW];
    for (int i = 0; i < WAYS; i++) begin
      if (WW'(i) == tway) n_rnk[i*WW +: WW] = '0;
      else if (e_rnk[i*WW +: WW] < trank) n_rnk[i*WW +: WW] = e_rnk[i*WW +: WW] + 1'b1;
      else n_rnk[i*WW +: WW] = e_rnk[i*WW +: WW];
    end
    n_tag = r_tag;
    n_tag[tway*TW +: TW] = tag;

    bfound = 1'b0;
    bsel = '0;
    bpos = '0;
    brank = '0;
    for (int i = 0; i < NUM_STREAMS; i++) begin
      bm = 1'b0;
      for (int j = STREAM_DEPTH - 1; j >= 0; j--) begin
        if (sblk[i][j] == blk) begin
          bm = 1'b1;
        end
      end
      if (svalid[i] && bm && (!bfound || srank[i] < brank)) begin
        bfound = 1'b1;
        bsel = NW'(i);
        brank = srank[i];
        bpos = '0;
        for (int j = STREAM_DEPTH - 1; j >= 0; j--) begin
          if (sblk[i][j] == blk) bpos = PFCNT_W'(j);
        end
      end
    end
    bfound = bfound && pf_en;
    asel = '0;
    for (int i = 0; i < NUM_STREAMS; i++) begin
      if (srank[i] == STR_LAST) asel = NW'(i);
    end
    do_alloc = pf_en && !bfound && !hit;
    stouch = bfound || do_alloc;
    tstr = bfound ? bsel : asel;
    strank = srank[tstr];
    for (int i = 0; i < NUM_STREAMS; i++) begin
      if (NW'(i) == tstr) srank_next[i] = '0;
      else if (srank[i] < strank) srank_next[i] = srank[i] + 1'b1;
      else srank_next[i] = srank[i];
    end
    fblk = blk + BW'(1);

    rsp = '0;
    rsp.hit = hit;
    rsp.buffer_hit = bfound;
    rsp.miss_counted = !hit && !bfound;
    rsp.fetch_needed = !hit && !bfound;
    if (!hit && e_drt[vict]) begin
      rsp.writeback = 1'b1;
      rsp.writeback_addr = ADDR_W'({r_tag[vict*TW +: TW], set_q, OB'(0)} >> (SW - IB));
    end
    if (bfound) begin
      rsp.prefetch_count = bpos + PFCNT_W'(1);
      rsp.prefetch_first_block =
        BLKNUM_W'(blk + BW'(STREAM_DEPTH) - BW'(bpos));
    end else if (do_alloc) begin
      rsp.prefetch_count = PFCNT_W'(STREAM_DEPTH);
      rsp.prefetch_first_block = BLKNUM_W'(fblk);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid) begin
      r_vld <= vld_mem[set_in];
      r_drt <= drt_mem[set_in];
      r_tag <= tag_mem[set_in];
      r_rnk <= rnk_mem[set_in];
      r_init <= row_init[set_in];
      cur <= q_req;
    end
    if (state == ST_EXEC && !out_full) begin
      vld_mem[set_q] <= e_vld | (WAYS'(1) << tway);
      drt_mem[set_q] <= hit ? (e_drt | (WAYS'(cur.cmd == CMD_WRITE) << hway))
                            : ((e_drt & ~(WAYS'(1) << vict))
                               | (WAYS'(cur.cmd == CMD_WRITE) << vict));
      tag_mem[set_q] <= n_tag;
      rnk_mem[set_q] <= n_rnk;
      out_rsp <= rsp;
      if (stouch) begin
        for (int k = 0; k < STREAM_DEPTH; k++) begin
          sblk[tstr][k] <= blk + BW'(k + 1);
        end
      end
    end
    if (rst) begin
      state <= ST_IDLE;
      out_full <= 1'b0;
      row_init <= '0;
      svalid <= '0;
      for (int i = 0; i < NUM_STREAMS; i++) begin
        srank[i] <= NW'(i);
        for (int k = 0; k < STREAM_DEPTH; k++) sblk[i][k] <= '0;
      end
    end else begin
      if (out_full && out_ready) out_full <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid) state <= ST_EXEC;
        end
        ST_EXEC: begin
          if (!out_full) begin
            out_full <= 1'b1;
            state <= ST_IDLE;
            row_init[set_q] <= 1'b1;
            if (stouch) srank <= srank_next;
            if (do_alloc) svalid[asel] <= 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* tb/cache_access_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// cache_access_checker
// Watches the access and result streams of the cache tag controller, keeps
// its own copy of line and stream-buffer state, and compares every result.
// ---------------------------------------------------------------------------
`default_nettype none

module cache_access_checker
  import sacp_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire         cfg_wdata,
  input  wire         s_axis_tvalid,
  input  wire         s_axis_tready,
  input  wire [31:0]  s_axis_tdata,
  input  wire         s_axis_tuser,
  input  wire         m_axis_tvalid,
  input  wire         m_axis_tready,
  input  wire [71:0]  m_axis_tdata,
  output int          fail_count,
  output int          pending_count
);

  localparam int SETS = 64;
  localparam int WAYS = 4;
  localparam int OB = 5;
  localparam int IB = 6;
  localparam int NS = 4;
  localparam int SD = 4;

  logic        line_vld [SETS*WAYS];
  logic        line_drt [SETS*WAYS];
  logic [20:0] line_tg  [SETS*WAYS];
  logic [1:0]  line_rk  [SETS*WAYS];
  logic [26:0] sb_blk   [NS*SD];
  logic [1:0]  sb_rk    [NS];
  logic        sb_vld   [NS];
  logic        pf_en;
  rsp_t        expected_rsp_q[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  task automatic touch_line(input int base, input int w);
    logic [1:0] r;
    r = line_rk[base+w];
    for (int i = 0; i < WAYS; i++)
      if (line_rk[base+i] < r) line_rk[base+i]++;
    line_rk[base+w] = 0;
  endtask

  task automatic touch_buf(input int s);
    logic [1:0] r;
    r = sb_rk[s];
    for (int i = 0; i < NS; i++)
      if (sb_rk[i] < r) sb_rk[i]++;
    sb_rk[s] = 0;
  endtask

  task automatic predict_access(input logic wr, input logic [31:0] addr);
    rsp_t        r;
    logic [26:0] blk;
    logic [5:0]  set;
    logic [20:0] tg;
    int          base, found, pos, victim, s;
    r = '0;
    blk = addr[31:OB];
    set = blk[IB-1:0];
    tg = addr[31:OB+IB];
    base = set * WAYS;
    found = -1;
    pos = 0;
    if (pf_en) begin
      for (int i = 0; i < NS; i++) begin
        if (sb_vld[i]) begin
          for (int j = 0; j < SD; j++) begin
            if (sb_blk[i*SD+j] == blk) begin
              if (found < 0 || sb_rk[i] < sb_rk[found]) begin
                found = i;
                pos = j;
              end
              break;
            end
          end
        end
      end
      if (found >= 0) begin
        r.buffer_hit = 1;
        for (int k = 0; k < SD; k++) sb_blk[found*SD+k] = blk + 27'(1 + k);
        touch_buf(found);
        r.prefetch_count = 3'(pos + 1);
        r.prefetch_first_block = blk + 27'(SD - pos);
      end
    end
    for (int i = 0; i < WAYS; i++) begin
      if (line_vld[base+i] && line_tg[base+i] == tg) begin
        r.hit = 1;
        touch_line(base, i);
        if (wr) line_drt[base+i] = 1;
        break;
      end
    end
    if (!r.hit) begin
      victim = 0;
      for (int i = 0; i < WAYS; i++)
        if (line_rk[base+i] == WAYS - 1) victim = i;
      if (pf_en && !r.buffer_hit) begin
        s = 0;
        for (int i = 0; i < NS; i++)
          if (sb_rk[i] == NS - 1) s = i;
        touch_buf(s);
        sb_vld[s] = 1;
        for (int k = 0; k < SD; k++) sb_blk[s*SD+k] = blk + 27'(1 + k);
        r.prefetch_count = 3'(SD);
        r.prefetch_first_block = blk + 27'd1;
      end
      if (line_drt[base+victim]) begin
        r.writeback = 1;
        r.writeback_addr = {line_tg[base+victim], set, 5'd0};
      end
      touch_line(base, victim);
      line_vld[base+victim] = 1;
      line_tg[base+victim] = tg;
      line_drt[base+victim] = wr;
    end
    r.miss_counted = !r.hit && !r.buffer_hit;
    r.fetch_needed = r.miss_counted;
    expected_rsp_q.push_back(r);
  endtask

  rsp_t got, want;

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SETS*WAYS; i++) begin
        line_vld[i] = 0;
        line_drt[i] = 0;
        line_tg[i] = 0;
        line_rk[i] = 2'(i % WAYS);
      end
      for (int i = 0; i < NS*SD; i++) sb_blk[i] = 0;
      for (int i = 0; i < NS; i++) begin
        sb_rk[i] = 2'(i);
        sb_vld[i] = 0;
      end
      pf_en = 0;
      fail_count = 0;
      expected_rsp_q.delete();
    end else begin
      if (cfg_we) pf_en = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready)
        predict_access(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        got.hit = m_axis_tdata[0];
        got.buffer_hit = m_axis_tdata[1];
        got.miss_counted = m_axis_tdata[2];
        got.fetch_needed = m_axis_tdata[3];
        got.writeback = m_axis_tdata[4];
        got.writeback_addr = m_axis_tdata[36:5];
        got.prefetch_count = m_axis_tdata[39:37];
        got.prefetch_first_block = m_axis_tdata[66:40];
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          want = expected_rsp_q.pop_front();
          if (got.hit != want.hit) report_mismatch("hit", got.hit, want.hit);
          if (got.buffer_hit != want.buffer_hit)
            report_mismatch("buffer_hit", got.buffer_hit, want.buffer_hit);
          if (got.miss_counted != want.miss_counted)
            report_mismatch("miss_counted", got.miss_counted, want.miss_counted);
          if (got.fetch_needed != want.fetch_needed)
            report_mismatch("fetch_needed", got.fetch_needed, want.fetch_needed);
          if (got.writeback != want.writeback)
            report_mismatch("writeback", got.writeback, want.writeback);
          if (got.writeback_addr != want.writeback_addr)
            report_mismatch("writeback_addr", got.writeback_addr, want.writeback_addr);
          if (got.prefetch_count != want.prefetch_count)
            report_mismatch("prefetch_count", got.prefetch_count, want.prefetch_count);
          if (got.prefetch_first_block != want.prefetch_first_block)
            report_mismatch("prefetch_first_block", got.prefetch_first_block,
                            want.prefetch_first_block);
        end
      end
    end
    pending_count = expected_rsp_q.size();
  end

endmodule

`default_nettype wire

/* tb/tb_set_assoc_cache_with_stream_prefetch_core.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_set_assoc_cache_with_stream_prefetch_core
// Drives directed and random cache accesses in phases with prefetching off
// and on, with random stalls on both streams and a long output hold-off.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_set_assoc_cache_with_stream_prefetch_core;
  import sacp_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic        cfg_wdata = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [71:0] m_axis_tdata;
  int          fail_count, pending_count;
  int          src_idle_pct = 22;
  int          sink_idle_pct = 22;
  int          holdoff_cycles = 0;
  logic [31:0] stream_addr;

  always #1 clk = ~clk;

  set_assoc_cache_with_stream_prefetch_core i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  cache_access_checker i_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // sink: random stalls, plus a counted hold-off when requested
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 0;
    end else if (holdoff_cycles > 0) begin
      m_axis_tready <= 0;
      holdoff_cycles <= holdoff_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_access(input logic wr, input logic [31:0] addr);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= addr;
    s_axis_tuser <= wr;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_prefetch(input logic en);
    s_axis_tvalid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1;
    cfg_wdata <= en;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // random addresses, a small address pool so sets fill, hit and evict, and
  // sequential runs that exercise stream buffers
  task automatic random_phase(input int count);
    logic [31:0] a;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(3))
        0: a = $urandom;
        1: a = {$urandom_range(7) == 0 ? 21'h1fffff : 21'($urandom_range(6)),
                6'($urandom_range(3)), 5'($urandom)};
        default: begin
          if ($urandom_range(5) == 0) stream_addr = $urandom;
          stream_addr = stream_addr + 32'd32 * $urandom_range(1, 2);
          a = stream_addr;
        end
      endcase
      send_access(1'($urandom_range(1)), a);
    end
  endtask

  initial begin
    #200000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    stream_addr = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: extremes, read/write hit, dirty eviction
    send_access(CMD_READ, 32'h0000_0000);
    send_access(CMD_WRITE, 32'h0000_0000);
    send_access(CMD_WRITE, 32'hFFFF_FFFF);
    send_access(CMD_READ, 32'hFFFF_FFE0);
    for (int t = 1; t <= 5; t++) send_access(CMD_WRITE, {21'(t), 6'd0, 5'd7});
    send_access(CMD_READ, 32'h0000_0000);
    set_prefetch(1);
    // new stream, buffer hits at different positions, wrap at top of address space
    send_access(CMD_READ, 32'h0000_1000);
    send_access(CMD_READ, 32'h0000_1020);
    send_access(CMD_READ, 32'h0000_1060);
    send_access(CMD_READ, 32'h0000_1000);
    send_access(CMD_WRITE, 32'hFFFF_FFC0);
    send_access(CMD_READ, 32'hFFFF_FFE0);
    send_access(CMD_READ, 32'h0000_0000);
    for (int t = 0; t < 5; t++) send_access(CMD_READ, 32'h0010_0000 * t);
    src_idle_pct = 0;
    sink_idle_pct = 0;
    random_phase(150);
    src_idle_pct = 22;
    sink_idle_pct = 22;
    holdoff_cycles = 60;
    random_phase(350);
    set_prefetch(0);
    random_phase(250);
    set_prefetch(1);
    random_phase(350);
    s_axis_tvalid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
hw/rtl/sacp_pkg.sv
hw/rtl/sacp_front.sv
hw/rtl/sacp_back.sv
hw/rtl/set_assoc_cache_with_stream_prefetch_core.sv
tb/cache_access_checker.sv
tb/tb_set_assoc_cache_with_stream_prefetch_core.sv
